@@ hw/rtl/view_frustum_culling_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the view frustum culling block
// Shared clocking and reset handling for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef VIEW_FRUSTUM_CULLING_MACROS_SVH
`define VIEW_FRUSTUM_CULLING_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define VFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/vfc_pkg.sv @@
// ----------------------------------------------------------------------------
// vfc_pkg
// Types, constants and helpers shared by the frustum culling modules.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int PlaneCount   = 6;
  localparam int MatDepth     = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int AccWidth     = 67;
  localparam int SqrtSteps    = 32;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_REBUILD = 2'd1,
    MODE_BOX     = 2'd2,
    MODE_SPHERE  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE, S_EXT, S_SQM, S_SQA, S_RTS, S_RTW, S_CHK, S_DVS, S_DVW,
    S_WR, S_QM, S_QA, S_QD, S_QC, S_EMIT
  } state_e;

  typedef enum logic {
    MUL_SQ,
    MUL_QRY
  } mul_src_e;

  typedef struct packed {
    logic       item_ld;
    logic       mat_we;
    logic [3:0] mat_addr;
    logic       base_ld;
    logic       vec_ld;
    logic       sub;
    logic [1:0] k;
    logic [2:0] p;
    logic       mul_en;
    mul_src_e   mul_src;
    logic       acc_clr;
    logic       acc_add;
    logic       acc_add_d;
    logic       sqrt_go;
    logic       mag_ld;
    logic       div_go;
    logic       div_ld;
    logic       pln_we;
    logic       vis_clr;
    logic       vis_chk;
    logic       out_set;
  } cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic unit_done;
    logic out_free;
  } sts_t;

  // clamp a 33-bit sum or difference to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/vfc_chan_if.sv @@
// ----------------------------------------------------------------------------
// vfc_in_if / vfc_out_if
// Valid/ready channels for query items and culling answers.
// ----------------------------------------------------------------------------
interface vfc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [3:0]         elem_index;
  logic signed [31:0] elem_value;
  logic signed [31:0] point_a_x;
  logic signed [31:0] point_a_y;
  logic signed [31:0] point_a_z;
  logic signed [31:0] point_b_x;
  logic signed [31:0] point_b_y;
  logic signed [31:0] point_b_z;
  logic [30:0]        sphere_radius;

  modport source (
    output valid, mode, elem_index, elem_value, point_a_x, point_a_y, point_a_z,
           point_b_x, point_b_y, point_b_z, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, mode, elem_index, elem_value, point_a_x, point_a_y, point_a_z,
           point_b_x, point_b_y, point_b_z, sphere_radius,
    output ready
  );
endinterface

interface vfc_out_if;
  logic valid;
  logic ready;
  logic visible;
  logic query_kind;

  modport source (output valid, visible, query_kind, input ready);
  modport sink   (input valid, visible, query_kind, output ready);
endinterface

@@ hw/rtl/vfc_root_div.sv @@
// ----------------------------------------------------------------------------
// vfc_root_div
// Shared iterative unit: 64-bit integer square root and radix-2 divider.
// ----------------------------------------------------------------------------
module vfc_root_div #(
  parameter int FRAC_BITS = vfc_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    sqrt_go_i,
  input  logic                    div_go_i,
  input  logic [63:0]             rad_i,
  input  logic [31:0]             num_i,
  input  logic [32:0]             den_i,
  output logic                    done_o,
  output logic [32:0]             root_o,
  output logic [32+FRAC_BITS-1:0] quo_o
);

  localparam int QW = 32 + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          div_q, div_d;
  logic          done_q, done_d;
  logic [63:0]   x_q, x_d, res_q, res_d, bit_q, bit_d;
  logic [32:0]   rem_q, rem_d, den_q, den_d;
  logic [QW-1:0] dvd_q, dvd_d;
  logic [63:0]   trial_sq;
  logic [33:0]   trial_dv;

  always_comb begin
    cnt_d    = cnt_q;
    div_d    = div_q;
    done_d   = 1'b0;
    x_d      = x_q;
    res_d    = res_q;
    bit_d    = bit_q;
    rem_d    = rem_q;
    den_d    = den_q;
    dvd_d    = dvd_q;
    trial_sq = res_q + bit_q;
    trial_dv = {rem_q, dvd_q[QW-1]};
    if (sqrt_go_i) begin
      cnt_d = CW'(vfc_pkg::SqrtSteps);
      div_d = 1'b0;
      x_d   = rad_i;
      res_d = '0;
      bit_d = 64'h4000_0000_0000_0000;
    end else if (div_go_i) begin
      cnt_d = CW'(QW);
      div_d = 1'b1;
      rem_d = '0;
      den_d = den_i;
      dvd_d = {num_i, {FRAC_BITS{1'b0}}};
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
      if (div_q) begin
        // shift in one dividend bit, quotient bit enters at the bottom
        if (trial_dv >= {1'b0, den_q}) begin
          rem_d = 33'(trial_dv - {1'b0, den_q});
          dvd_d = {dvd_q[QW-2:0], 1'b1};
        end else begin
          rem_d = trial_dv[32:0];
          dvd_d = {dvd_q[QW-2:0], 1'b0};
        end
      end else begin
        if (x_q >= trial_sq) begin
          x_d   = x_q - trial_sq;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      div_q  <= div_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    res_q <= res_d;
    bit_q <= bit_d;
    rem_q <= rem_d;
    den_q <= den_d;
    dvd_q <= dvd_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[32:0];
  assign quo_o  = dvd_q;

endmodule

@@ hw/rtl/vfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// vfc_ctrl
// Sequencer for matrix loads, plane rebuilds and shape queries.
// ----------------------------------------------------------------------------
module vfc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_mode_i,
  output logic          in_ready_o,
  input  vfc_pkg::sts_t sts_i,
  output vfc_pkg::cmd_t cmd_o
);

  localparam logic [2:0] LastPlane = 3'(vfc_pkg::PlaneCount - 1);

  vfc_pkg::state_e state_q, state_d;
  logic [2:0] p_q, p_d;
  logic [1:0] k_q, k_d;
  logic       half_q, half_d;

  // next state and loop counters
  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    k_d     = k_q;
    half_d  = half_q;
    case (state_q)
      vfc_pkg::S_IDLE: begin
        p_d    = '0;
        k_d    = '0;
        half_d = 1'b0;
        if (in_valid_i) begin
          case (in_mode_i)
            vfc_pkg::MODE_REBUILD: state_d = vfc_pkg::S_EXT;
            vfc_pkg::MODE_BOX,
            vfc_pkg::MODE_SPHERE:  state_d = vfc_pkg::S_QM;
            default:               state_d = vfc_pkg::S_IDLE;
          endcase
        end
      end
      vfc_pkg::S_EXT: begin
        half_d = ~half_q;
        if (half_q) begin
          if (k_q == 2'd3) begin
            k_d     = '0;
            state_d = vfc_pkg::S_SQM;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      vfc_pkg::S_SQM: state_d = vfc_pkg::S_SQA;
      vfc_pkg::S_SQA: begin
        if (k_q == 2'd2) begin
          state_d = vfc_pkg::S_RTS;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = vfc_pkg::S_SQM;
        end
      end
      vfc_pkg::S_RTS: state_d = vfc_pkg::S_RTW;
      vfc_pkg::S_RTW: if (sts_i.unit_done) state_d = vfc_pkg::S_CHK;
      vfc_pkg::S_CHK: begin
        k_d     = '0;
        state_d = sts_i.mag_zero ? vfc_pkg::S_WR : vfc_pkg::S_DVS;
      end
      vfc_pkg::S_DVS: state_d = vfc_pkg::S_DVW;
      vfc_pkg::S_DVW: begin
        if (sts_i.unit_done) begin
          if (k_q == 2'd3) begin
            state_d = vfc_pkg::S_WR;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = vfc_pkg::S_DVS;
          end
        end
      end
      vfc_pkg::S_WR: begin
        k_d = '0;
        if (p_q == LastPlane) begin
          state_d = vfc_pkg::S_IDLE;
        end else begin
          p_d     = p_q + 3'd1;
          state_d = vfc_pkg::S_EXT;
        end
      end
      vfc_pkg::S_QM: state_d = vfc_pkg::S_QA;
      vfc_pkg::S_QA: begin
        if (k_q == 2'd2) begin
          // point at the distance term for the offset add
          k_d     = 2'd3;
          state_d = vfc_pkg::S_QD;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = vfc_pkg::S_QM;
        end
      end
      vfc_pkg::S_QD: state_d = vfc_pkg::S_QC;
      vfc_pkg::S_QC: begin
        k_d = '0;
        if (p_q == LastPlane) begin
          state_d = vfc_pkg::S_EMIT;
        end else begin
          p_d     = p_q + 3'd1;
          state_d = vfc_pkg::S_QM;
        end
      end
      vfc_pkg::S_EMIT: if (sts_i.out_free) state_d = vfc_pkg::S_IDLE;
      default: state_d = vfc_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.k    = k_q;
    cmd_o.p    = p_q;
    cmd_o.sub  = p_q[0];
    case (state_q)
      vfc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_ld = 1'b1;
          case (in_mode_i)
            vfc_pkg::MODE_LOAD: cmd_o.mat_we = 1'b1;
            vfc_pkg::MODE_BOX,
            vfc_pkg::MODE_SPHERE: begin
              cmd_o.vis_clr = 1'b1;
              cmd_o.acc_clr = 1'b1;
            end
            default: cmd_o.item_ld = 1'b1;
          endcase
        end
      end
      vfc_pkg::S_EXT: begin
        // base column entry first, then the row entry for this plane
        cmd_o.mat_addr = half_q ? {k_q, p_q[2:1]} : {k_q, 2'b11};
        cmd_o.base_ld  = ~half_q;
        cmd_o.vec_ld   = half_q;
        cmd_o.acc_clr  = half_q && (k_q == 2'd3);
      end
      vfc_pkg::S_SQM: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_src = vfc_pkg::MUL_SQ;
      end
      vfc_pkg::S_SQA:  cmd_o.acc_add = 1'b1;
      vfc_pkg::S_RTS:  cmd_o.sqrt_go = 1'b1;
      vfc_pkg::S_RTW:  cmd_o.mag_ld  = sts_i.unit_done;
      vfc_pkg::S_DVS:  cmd_o.div_go  = 1'b1;
      vfc_pkg::S_DVW:  cmd_o.div_ld  = sts_i.unit_done;
      vfc_pkg::S_WR:   cmd_o.pln_we  = 1'b1;
      vfc_pkg::S_QM: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_src = vfc_pkg::MUL_QRY;
      end
      vfc_pkg::S_QA:   cmd_o.acc_add   = 1'b1;
      vfc_pkg::S_QD:   cmd_o.acc_add_d = 1'b1;
      vfc_pkg::S_QC: begin
        cmd_o.vis_chk = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      vfc_pkg::S_EMIT: cmd_o.out_set = sts_i.out_free;
      default:         cmd_o.acc_clr = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vfc_pkg::S_IDLE;
      p_q     <= '0;
      k_q     <= '0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      k_q     <= k_d;
      half_q  <= half_d;
    end
  end

endmodule

@@ hw/rtl/vfc_datapath.sv @@
// ----------------------------------------------------------------------------
// vfc_datapath
// Matrix and plane storage, shared multiplier, accumulator and result register.
// ----------------------------------------------------------------------------
module vfc_datapath #(
  parameter int FRAC_BITS = vfc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vfc_pkg::cmd_t      cmd_i,
  output vfc_pkg::sts_t      sts_o,
  input  logic [1:0]         mode_i,
  input  logic [3:0]         elem_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic signed [31:0] point_a_x_i,
  input  logic signed [31:0] point_a_y_i,
  input  logic signed [31:0] point_a_z_i,
  input  logic signed [31:0] point_b_x_i,
  input  logic signed [31:0] point_b_y_i,
  input  logic signed [31:0] point_b_z_i,
  input  logic [30:0]        sphere_radius_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               visible_o,
  output logic               query_kind_o
);

  localparam int QW = 32 + FRAC_BITS;
  localparam int AW = vfc_pkg::AccWidth;
  localparam logic [QW-1:0] QNegLim = {{(QW-32){1'b0}}, 32'h8000_0000};
  localparam logic [QW-1:0] QPosLim = {{(QW-32){1'b0}}, 32'h7fff_ffff};

  logic signed [31:0] mat_q [vfc_pkg::MatDepth];
  logic signed [31:0] pln_q [vfc_pkg::PlaneCount][4];
  logic signed [31:0] vec_q [4];
  logic signed [31:0] base_q;
  logic signed [31:0] a_q [3];
  logic signed [31:0] b_q [3];
  logic [30:0]        rad_q;
  logic               sph_q;
  logic signed [63:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic [32:0]        mag_q;
  logic               vis_q;
  logic               out_vld_q, out_vis_q, out_kind_q;

  logic signed [31:0] mat_rd, sel_a, sel_b, sel_min, sel_max, cur_v, pw;
  logic signed [32:0] ext;
  logic [31:0]        abs_v;
  logic signed [31:0] div_v;
  logic               unit_done;
  logic [32:0]        root;
  logic [QW-1:0]      quo;
  logic [AW-1:0]      rlim;
  logic signed [AW-1:0] lim;
  logic               fail;

  assign mat_rd = mat_q[cmd_i.mat_addr];
  assign ext    = cmd_i.sub ? (33'(base_q) - 33'(mat_rd)) : (33'(base_q) + 33'(mat_rd));
  assign cur_v  = vec_q[cmd_i.k];
  assign pw     = pln_q[cmd_i.p][cmd_i.k];

  always_comb begin
    case (cmd_i.k)
      2'd0:    begin sel_min = a_q[0]; sel_max = b_q[0]; end
      2'd1:    begin sel_min = a_q[1]; sel_max = b_q[1]; end
      default: begin sel_min = a_q[2]; sel_max = b_q[2]; end
    endcase
  end

  // furthest corner along the normal for a box; centre for a sphere
  always_comb begin
    if (cmd_i.mul_src == vfc_pkg::MUL_SQ) begin
      sel_a = cur_v;
      sel_b = cur_v;
    end else begin
      sel_a = pw;
      sel_b = (!sph_q && pw > 32'sd0) ? sel_max : sel_min;
    end
  end

  assign abs_v = cur_v[31] ? 32'(-cur_v) : cur_v;

  always_comb begin
    if (cur_v[31]) begin
      div_v = (quo > QNegLim) ? 32'sh8000_0000 : 32'(-quo[31:0]);
    end else begin
      div_v = (quo > QPosLim) ? 32'sh7fff_ffff : quo[31:0];
    end
  end

  assign rlim = AW'(rad_q) << FRAC_BITS;
  assign lim  = -$signed(rlim);
  assign fail = sph_q ? (acc_q < lim) : (acc_q < $signed(AW'(0)));

  vfc_root_div #(.FRAC_BITS(FRAC_BITS)) u_root_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sqrt_go_i (cmd_i.sqrt_go),
    .div_go_i  (cmd_i.div_go),
    .rad_i     (acc_q[63:0]),
    .num_i     (abs_v),
    .den_i     (mag_q),
    .done_o    (unit_done),
    .root_o    (root),
    .quo_o     (quo)
  );

  // model state: matrix and planes reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vfc_pkg::MatDepth; i++) mat_q[i] <= '0;
      for (int i = 0; i < vfc_pkg::PlaneCount; i++) begin
        for (int j = 0; j < 4; j++) pln_q[i][j] <= '0;
      end
      vis_q      <= 1'b1;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.mat_we) mat_q[elem_index_i] <= elem_value_i;
      if (cmd_i.pln_we) begin
        for (int j = 0; j < 4; j++) pln_q[cmd_i.p][j] <= vec_q[j];
      end
      if (cmd_i.vis_clr) begin
        vis_q <= 1'b1;
      end else if (cmd_i.vis_chk) begin
        vis_q <= vis_q & ~fail;
      end
      if (cmd_i.out_set) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_ld) begin
      a_q[0] <= point_a_x_i;
      a_q[1] <= point_a_y_i;
      a_q[2] <= point_a_z_i;
      b_q[0] <= point_b_x_i;
      b_q[1] <= point_b_y_i;
      b_q[2] <= point_b_z_i;
      rad_q  <= sphere_radius_i;
      sph_q  <= (mode_i == vfc_pkg::MODE_SPHERE);
    end
    if (cmd_i.base_ld) base_q <= mat_rd;
    if (cmd_i.vec_ld)  vec_q[cmd_i.k] <= vfc_pkg::sat32(ext);
    if (cmd_i.div_ld)  vec_q[cmd_i.k] <= div_v;
    if (cmd_i.mul_en)  prod_q <= 64'(sel_a) * 64'(sel_b);
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + AW'(prod_q);
    end else if (cmd_i.acc_add_d) begin
      acc_q <= acc_q + (AW'(pw) <<< FRAC_BITS);
    end
    if (cmd_i.mag_ld) mag_q <= root;
    if (cmd_i.out_set) begin
      out_vis_q  <= vis_q;
      out_kind_q <= sph_q;
    end
  end

  assign sts_o.mag_zero  = (mag_q == '0);
  assign sts_o.unit_done = unit_done;
  assign sts_o.out_free  = ~out_vld_q | out_ready_i;

  assign out_valid_o  = out_vld_q;
  assign visible_o    = out_vis_q;
  assign query_kind_o = out_kind_q;

endmodule

@@ hw/rtl/view_frustum_culling.sv @@
// ----------------------------------------------------------------------------
// view_frustum_culling
// Clip-plane extraction from a view-projection matrix and box/sphere culling.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat
// in_i     in   mode, elem_index, elem_value, point_a_*, point_b_*, sphere_radius
// out_o    out  visible, query_kind
//
// A load beat leaves in_i ready for the next beat. A box or sphere query makes
// one multiply and one accumulate per normal term on the shared multiplier, six
// planes in turn. A rebuild runs the bit-serial square root once and the divider
// four times per plane; a plane with a zero-length normal skips its four divides.
// Reset clears the matrix and all planes at once. A held answer stalls the
// next query only at its end; in_i is taken while out_o waits.
// ----------------------------------------------------------------------------
`include "view_frustum_culling_macros.svh"

module view_frustum_culling #(
  parameter int FRAC_BITS = vfc_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  vfc_in_if.sink    in_i,
  vfc_out_if.source out_o
);

  vfc_pkg::cmd_t cmd;
  vfc_pkg::sts_t sts;

  vfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vfc_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (in_i.mode),
    .elem_index_i    (in_i.elem_index),
    .elem_value_i    (in_i.elem_value),
    .point_a_x_i     (in_i.point_a_x),
    .point_a_y_i     (in_i.point_a_y),
    .point_a_z_i     (in_i.point_a_z),
    .point_b_x_i     (in_i.point_b_x),
    .point_b_y_i     (in_i.point_b_y),
    .point_b_z_i     (in_i.point_b_z),
    .sphere_radius_i (in_i.sphere_radius),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .visible_o       (out_o.visible),
    .query_kind_o    (out_o.query_kind)
  );

  `VFC_ASSERT_NXT(a_query_busy, in_i.valid && in_i.ready && (in_i.mode == vfc_pkg::MODE_BOX || in_i.mode == vfc_pkg::MODE_SPHERE), !in_i.ready, "query beat did not occupy the sequencer")
  `VFC_ASSERT_NXT(a_load_single, in_i.valid && in_i.ready && in_i.mode == vfc_pkg::MODE_LOAD, in_i.ready, "load beat held the input")
  `VFC_ASSERT_NXT(a_emit_shown, cmd.out_set, out_o.valid, "answer not presented after emit")
  `VFC_ASSERT_IMP(a_unit_quiet, in_i.ready, !sts.unit_done, "root/divide unit finished while idle")

endmodule
